>>> rtl/ycbd_pkg.sv
// ycbd_pkg: shared types, constants, and functions for the yolo cell box decoder
// includes the 257-entry sigmoid table and the anchor tables
// has no dependencies
package ycbd_pkg;

	localparam int MaxGridDefault = 128;
	localparam logic [23:0] ProbScaleMax = 24'd8192;
	localparam logic signed [7:0] ProbZeroPoint = -8'sd128;
	localparam logic [15:0] ThresholdReset = 16'd32768;

	// configuration register indexes
	localparam logic [2:0] RegThreshold = 3'd0;
	localparam logic [2:0] RegZp0 = 3'd1;
	localparam logic [2:0] RegZp2 = 3'd3;
	localparam logic [2:0] RegScale0 = 3'd4;
	localparam logic [2:0] RegScale2 = 3'd6;

	// front-to-back queue entry
	typedef struct packed {
		logic [1:0] level;
		logic [1:0] anchor;
		logic [6:0] col;
		logic [6:0] row;
		logic [5:0][7:0] raw;
		logic signed [7:0] zp;
		logic [23:0] scale;
		logic prob;
	} cell_t;

	// anchor size per level and table slot, slot = anchor*2 + (0 width, 1 height)
	function automatic logic [8:0] anchor_size(input logic [1:0] lvl, input logic [2:0] slot);
		logic [8:0] v;
		v = 9'd0;
		case (lvl)
			2'd0: begin
				case (slot)
					3'd0: v = 9'd10;  3'd1: v = 9'd13;  3'd2: v = 9'd16;
					3'd3: v = 9'd30;  3'd4: v = 9'd33;  3'd5: v = 9'd23;
					default: v = 9'd0;
				endcase
			end
			2'd1: begin
				case (slot)
					3'd0: v = 9'd30;  3'd1: v = 9'd61;  3'd2: v = 9'd62;
					3'd3: v = 9'd45;  3'd4: v = 9'd59;  3'd5: v = 9'd119;
					default: v = 9'd0;
				endcase
			end
			2'd2: begin
				case (slot)
					3'd0: v = 9'd116; 3'd1: v = 9'd90;  3'd2: v = 9'd156;
					3'd3: v = 9'd198; 3'd4: v = 9'd373; 3'd5: v = 9'd326;
					default: v = 9'd0;
				endcase
			end
			default: v = 9'd0;
		endcase
		return v;
	endfunction

	// sigmoid table entry for step k, built at elaboration from the exp recurrence
	function automatic logic [15:0] sig_entry(input int k);
		logic [127:0] e;
		logic [127:0] den;
		logic [127:0] num;
		logic [127:0] rem;
		logic [127:0] s;
		e = 128'd1 << 32;
		for (int i = 0; i < k; i++)
			e = (e * 128'd4162825044 + (128'd1 << 31)) >> 32;
		den = (128'd1 << 32) + e;
		num = (128'd1 << 48) + (den >> 1);
		// restoring long division of num by den
		rem = '0;
		s = '0;
		for (int b = 49; b >= 0; b--) begin
			rem = {rem[126:0], num[b]};
			if (rem >= den) begin
				rem = rem - den;
				s[b] = 1'b1;
			end
		end
		if (s > 128'd65535)
			s = 128'd65535;
		return s[15:0];
	endfunction

	typedef logic [256:0][15:0] sig_rom_t;

	function automatic sig_rom_t build_sig_rom();
		sig_rom_t r;
		for (int k = 0; k <= 256; k++)
			r[k] = sig_entry(k);
		return r;
	endfunction

	localparam sig_rom_t SigRom = build_sig_rom();

endpackage

>>> rtl/yolo_cell_box_decode_unit.sv
// yolo_cell_box_decode_unit: top level of the detection-head cell decoder
// depends on ycbd_pkg, ycbd_front, ycbd_back
//
// Accepts one cell per clock unless the queue is full and not being popped, and
// gives at most one box per cell, presented on the output by the back end, a
// five-stage pipeline (dequant multiply, sigmoid table, score multiply, size
// squares, rounding) fed from a two-entry queue. Cells with a bad level, anchor
// or grid position, or below the confidence threshold, produce nothing.
// Configuration writes are taken every cycle and should be made while the block
// is idle.
module yolo_cell_box_decode_unit #(
	parameter int MAX_GRID = ycbd_pkg::MaxGridDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic  [2:0] cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic  [1:0] level,
	input  logic  [1:0] anchor_index,
	input  logic  [6:0] cell_col,
	input  logic  [6:0] cell_row,
	input  logic  [7:0] raw_center_x,
	input  logic  [7:0] raw_center_y,
	input  logic  [7:0] raw_width,
	input  logic  [7:0] raw_height,
	input  logic  [7:0] raw_objectness,
	input  logic  [7:0] raw_class,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [19:0] box_left,
	output logic [19:0] box_top,
	output logic [19:0] box_width,
	output logic [19:0] box_height,
	output logic [15:0] box_score
);
	import ycbd_pkg::*;

	logic [15:0] threshold;
	logic        q_valid;
	logic        q_pop;
	cell_t       q_head;

	ycbd_front #(.MAX_GRID(MAX_GRID)) u_front (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .level, .anchor_index, .cell_col, .cell_row,
		.raw_center_x, .raw_center_y, .raw_width, .raw_height,
		.raw_objectness, .raw_class,
		.threshold, .q_valid, .q_pop, .q_head
	);

	ycbd_back u_back (
		.clk, .arst_n, .threshold, .q_valid, .q_pop, .q_head,
		.out_valid, .out_ready, .box_left, .box_top, .box_width, .box_height, .box_score
	);
endmodule

>>> rtl/ycbd_lane.sv
// ycbd_lane: dequantizes one raw channel value and maps it to a Q0.16 probability
// two register stages: product, then table or saturation
// depends on ycbd_pkg
module ycbd_lane (
	input  logic              clk,
	input  logic              en_s1,
	input  logic              en_s2,
	input  logic        [7:0] raw,
	input  logic signed [7:0] zp,
	input  logic       [23:0] scale,
	input  logic              prob,
	output logic       [15:0] value_s2
);
	import ycbd_pkg::*;

	logic signed [8:0]  diff;
	logic signed [33:0] prod;
	logic signed [33:0] d_s1;
	logic               prob_s1;
	logic        [33:0] mag;
	logic        [33:0] kwide;
	logic         [8:0] k;
	logic        [15:0] s;
	logic        [33:0] pv;
	logic        [15:0] res;

	// dequantize: (raw - zp) * scale
	assign diff = 9'(signed'(raw)) - 9'(zp);
	assign prod = 34'(diff) * signed'({1'b0, 24'(scale)});

	always_ff @(posedge clk) begin
		if (en_s1) begin
			d_s1 <= prod;
			prob_s1 <= prob;
		end
	end

	// sigmoid step index and probability-path saturation
	always_comb begin
		mag = d_s1[33] ? 34'(-d_s1) : 34'(d_s1);
		kwide = (mag + 34'd16384) >> 15;
		k = (kwide > 34'd256) ? 9'd256 : kwide[8:0];
		s = SigRom[k];
		pv = 34'(d_s1 + 34'sd8) >> 4;
		if (prob_s1) begin
			if (d_s1[33])
				res = 16'd0;
			else if (pv > 34'd65535)
				res = 16'hFFFF;
			else
				res = pv[15:0];
		end else begin
			res = d_s1[33] ? 16'(17'd65536 - 17'(s)) : s;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2)
			value_s2 <= res;
	end
endmodule

>>> rtl/ycbd_front.sv
// ycbd_front: config registers, item acceptance, validity classification
// feeds a two-entry queue toward the back end
// depends on ycbd_pkg
module ycbd_front #(
	parameter int MAX_GRID = ycbd_pkg::MaxGridDefault
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic            [2:0] cfg_index,
	input  logic           [23:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic            [1:0] level,
	input  logic            [1:0] anchor_index,
	input  logic            [6:0] cell_col,
	input  logic            [6:0] cell_row,
	input  logic            [7:0] raw_center_x,
	input  logic            [7:0] raw_center_y,
	input  logic            [7:0] raw_width,
	input  logic            [7:0] raw_height,
	input  logic            [7:0] raw_objectness,
	input  logic            [7:0] raw_class,
	output logic           [15:0] threshold,
	output logic                  q_valid,
	input  logic                  q_pop,
	output ycbd_pkg::cell_t       q_head
);
	import ycbd_pkg::*;

	logic [15:0]            thr_q;
	logic [2:0][7:0]        zp_q;
	logic [2:0][23:0]       scale_q;
	cell_t [1:0]            fifo_q;
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [1:0]             cnt_q;
	logic                   push;
	logic                   keep;
	logic [1:0]             lv;
	cell_t                  c;

	assign cfg_ready = 1'b1;
	assign threshold = thr_q;

	// config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= ThresholdReset;
			zp_q <= '0;
			scale_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == RegThreshold)
				thr_q <= cfg_data[15:0];
			else if (cfg_index >= RegZp0 && cfg_index <= RegZp2)
				zp_q[2'(cfg_index - RegZp0)] <= cfg_data[7:0];
			else if (cfg_index >= RegScale0 && cfg_index <= RegScale2)
				scale_q[2'(cfg_index - RegScale0)] <= cfg_data;
		end
	end

	// classify: drop bad level, anchor or grid position
	always_comb begin
		keep = (level != 2'd3) && (anchor_index != 2'd3)
			&& (32'(cell_col) < MAX_GRID) && (32'(cell_row) < MAX_GRID);
		lv = (level == 2'd3) ? 2'd0 : level;
		c.level = level;
		c.anchor = anchor_index;
		c.col = cell_col;
		c.row = cell_row;
		c.raw = {raw_class, raw_objectness, raw_height, raw_width, raw_center_y, raw_center_x};
		c.zp = signed'(zp_q[lv]);
		c.scale = scale_q[lv];
		c.prob = (signed'(zp_q[lv]) == ProbZeroPoint) && (scale_q[lv] != 24'd0)
			&& (scale_q[lv] <= ProbScaleMax);
	end

	assign in_ready = (cnt_q != 2'd2) || q_pop;
	assign push = in_valid && in_ready && keep;
	assign q_valid = cnt_q != 2'd0;
	assign q_head = fifo_q[rd_ptr_q];

	// two-entry queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (q_pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= c;
	end
endmodule

>>> rtl/ycbd_back.sv
// ycbd_back: dequant/sigmoid lanes, score test and box geometry pipeline
// stalls as a whole on output backpressure
// depends on ycbd_pkg and ycbd_lane
module ycbd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic           [15:0] threshold,
	input  logic                  q_valid,
	output logic                  q_pop,
	input  ycbd_pkg::cell_t       q_head,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic           [19:0] box_left,
	output logic           [19:0] box_top,
	output logic           [19:0] box_width,
	output logic           [19:0] box_height,
	output logic           [15:0] box_score
);
	import ycbd_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv;
	logic [1:0] lvl_s1, lvl_s2, lvl_s3, lvl_s4;
	logic [1:0] anc_s1, anc_s2;
	logic [6:0] col_s1, col_s2, row_s1, row_s2;
	logic [5:0][15:0] p_s2;
	logic [15:0] score_s3, score_s4;
	logic pass_s3;
	logic [15:0] px_s3, py_s3, pw_s3, ph_s3;
	logic [6:0] col_s3, row_s3;
	logic [8:0] aw_s3, ah_s3;
	logic [31:0] pw2_s4, ph2_s4;
	logic [8:0] aw_s4, ah_s4;
	logic signed [24:0] cxb_s4, cyb_s4;
	logic [31:0] obj_cls;
	logic [41:0] w36, h36;
	logic signed [47:0] cx, cy;
	logic signed [47:0] lft, tp;
	logic [19:0] left_r, top_r, w_r, h_r;

	// pipeline advances when the output register is free
	assign adv = !v_s5 || out_ready;
	assign q_pop = adv && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && pass_s3;
			v_s5 <= v_s4;
		end
	end

	// six dequant lanes
	for (genvar i = 0; i < 6; i++) begin : g_lane
		ycbd_lane u_lane (
			.clk      (clk),
			.en_s1    (adv),
			.en_s2    (adv),
			.raw      (q_head.raw[i]),
			.zp       (q_head.zp),
			.scale    (q_head.scale),
			.prob     (q_head.prob),
			.value_s2 (p_s2[i])
		);
	end

	// side-band through lane stages, then score and threshold test
	assign obj_cls = 32'(p_s2[4]) * 32'(p_s2[5]);

	always_ff @(posedge clk) begin
		if (adv) begin
			lvl_s1 <= q_head.level; anc_s1 <= q_head.anchor;
			col_s1 <= q_head.col; row_s1 <= q_head.row;
			lvl_s2 <= lvl_s1; anc_s2 <= anc_s1; col_s2 <= col_s1; row_s2 <= row_s1;
			score_s3 <= 16'((33'(obj_cls) + 33'd32768) >> 16);
			pass_s3 <= (p_s2[4] >= threshold)
				&& (16'((33'(obj_cls) + 33'd32768) >> 16) >= threshold);
			px_s3 <= p_s2[0]; py_s3 <= p_s2[1]; pw_s3 <= p_s2[2]; ph_s3 <= p_s2[3];
			col_s3 <= col_s2; row_s3 <= row_s2; lvl_s3 <= lvl_s2;
			aw_s3 <= anchor_size(lvl_s2, {anc_s2, 1'b0});
			ah_s3 <= anchor_size(lvl_s2, {anc_s2, 1'b1});
		end
	end

	// squares and centers in Q.16 units of grid cells
	always_ff @(posedge clk) begin
		if (adv) begin
			pw2_s4 <= 32'(pw_s3) * 32'(pw_s3);
			ph2_s4 <= 32'(ph_s3) * 32'(ph_s3);
			aw_s4 <= aw_s3; ah_s4 <= ah_s3;
			cxb_s4 <= 25'(signed'({1'b0, px_s3, 1'b0})) + 25'(signed'({1'b0, col_s3, 16'd0}))
				- 25'sd32768;
			cyb_s4 <= 25'(signed'({1'b0, py_s3, 1'b0})) + 25'(signed'({1'b0, row_s3, 16'd0}))
				- 25'sd32768;
			lvl_s4 <= lvl_s3; score_s4 <= score_s3;
		end
	end

	// sizes in Q.32 pixels are pw2*anchor*4; work with pw2*anchor, Q.32 scaled by 1/4 -> keep exact
	always_comb begin
		w36 = 42'(pw2_s4) * 42'(aw_s4);
		h36 = 42'(ph2_s4) * 42'(ah_s4);
		// center in Q.32 pixels = cxb * stride * 65536
		cx = 48'(cxb_s4) <<< (35 - 16 + {46'd0, lvl_s4});
		cy = 48'(cyb_s4) <<< (35 - 16 + {46'd0, lvl_s4});
		// corner = center - 4*w/2 = center - 2*w
		lft = cx - signed'({5'd0, w36, 1'b0});
		tp = cy - signed'({5'd0, h36, 1'b0});
		left_r = 20'((lft + 48'sd134217728) >>> 28);
		top_r = 20'((tp + 48'sd134217728) >>> 28);
		w_r = 20'((({6'd0, w36, 2'b00}) + 50'd134217728) >> 28);
		h_r = 20'((({6'd0, h36, 2'b00}) + 50'd134217728) >> 28);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			box_left <= left_r; box_top <= top_r;
			box_width <= w_r; box_height <= h_r;
			box_score <= score_s4;
		end
	end

	assign out_valid = v_s5;
endmodule
